[sv/stqi_pkg.sv]
package stqi_pkg;

  localparam int unsigned TABLE_DEPTH = 64;

  // lagrange term arithmetic widths
  localparam int unsigned NUM_W = 96;
  localparam int unsigned QR_W = NUM_W + 1;
  localparam int unsigned ACC_W = NUM_W + 3;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PREPEND = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_ORDER = 3'd3,
    ST_FEW   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_LAST  = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_RD   = 2'd1,
    RES_HIT  = 2'd2,
    RES_LAG  = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic     latch;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     scan_clr;
    logic     scan_inc;
    logic     wr_en;
    logic     lag_start;
    logic     res_load;
    res_sel_e res_sel;
    status_e  res_st;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_append;
    logic query_act;
    logic full;
    logic empty;
    logic few;
    logic x_lt;
    logic x_eq;
    logic x_gt;
    logic ord_bad;
    logic found;
    logic hit;
    logic scan_ge2;
    logic scan_last;
    logic lag_done;
  } dp_stat_t;

  // magnitude of a 33-bit two's complement difference of two unsigned words
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = ~v + 33'd1;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

endpackage

[sv/sorted_table_quadratic_interpolator.sv]
// Sorted sample table with quadratic interpolation. A request is taken when
// start is high and busy is low; exactly one result follows, shown on
// value_o/status_o for the single cycle in which done_o is high. The receiver
// cannot stall: it must take the result in that cycle. For an interpolating
// query the table is scanned one entry per cycle through the single memory
// read port, and each of the three Lagrange terms runs a shared 32x32
// multiplier and a restoring divider that produces one of 96 quotient bits
// per cycle. Threshold writes are accepted at any time but must only be made
// while busy is low.
module sorted_table_quadratic_interpolator #(
  parameter int unsigned TABLE_DEPTH = stqi_pkg::TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        abscissa_i,
  input  logic signed [31:0] ordinate_i,
  output logic               done_o,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  stqi_pkg::dp_cmd_t cmd;
  stqi_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  stqi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  stqi_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .operation_i (operation_i),
    .abscissa_i  (abscissa_i),
    .ordinate_i  (ordinate_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

[sv/stqi_lag.sv]
module stqi_lag (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        x0_i,
  input  logic [31:0]        x1_i,
  input  logic [31:0]        x2_i,
  input  logic signed [31:0] y0_i,
  input  logic signed [31:0] y1_i,
  input  logic signed [31:0] y2_i,
  output logic               done_o,
  output logic signed [31:0] result_o
);

  localparam int unsigned NW = stqi_pkg::NUM_W;
  localparam int unsigned QW = stqi_pkg::QR_W;
  localparam int unsigned AW = stqi_pkg::ACC_W;
  localparam int unsigned KW = stqi_pkg::DIV_CNT_W;

  typedef enum logic [9:0] {
    PH_IDLE = 10'b0000000001,
    PH_PQ   = 10'b0000000010,
    PH_DEN  = 10'b0000000100,
    PH_ML   = 10'b0000001000,
    PH_MH   = 10'b0000010000,
    PH_NUM  = 10'b0000100000,
    PH_DIV  = 10'b0001000000,
    PH_RND  = 10'b0010000000,
    PH_ACC  = 10'b0100000000,
    PH_SAT  = 10'b1000000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [1:0] term_q, term_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic done_q;

  logic [31:0] x_q, x0_q, x1_q, x2_q;
  logic [31:0] y0_q, y1_q, y2_q;
  logic [63:0] pq_q, den_q, lo_q, hi_q;
  logic [NW-1:0] dq_q;
  logic [63:0] rem_q;
  logic [QW-1:0] qr_q;
  logic neg_q;
  logic signed [AW-1:0] acc_q;
  logic signed [31:0] res_q;

  logic [32:0] da, db, dc;
  logic [31:0] d01, d02, d12;
  logic [32:0] p_s, q_s;
  logic flip;
  logic [31:0] ysel, ymag, den_a, den_b;
  logic neg;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] r_sh, r_sub;
  logic q_bit, rnd;
  logic signed [AW-1:0] qext;
  logic fits;

  assign da = {1'b0, x_q} - {1'b0, x0_q};
  assign db = {1'b0, x_q} - {1'b0, x1_q};
  assign dc = {1'b0, x_q} - {1'b0, x2_q};
  assign d01 = x1_q - x0_q;
  assign d02 = x2_q - x0_q;
  assign d12 = x2_q - x1_q;

  always_comb begin
    unique case (term_q)
      2'd0: begin
        p_s = db; q_s = dc; flip = 1'b0; ysel = y0_q; den_a = d01; den_b = d02;
      end
      2'd1: begin
        p_s = da; q_s = dc; flip = 1'b1; ysel = y1_q; den_a = d01; den_b = d12;
      end
      default: begin
        p_s = da; q_s = db; flip = 1'b0; ysel = y2_q; den_a = d02; den_b = d12;
      end
    endcase
  end

  assign ymag = ysel[31] ? (~ysel + 32'd1) : ysel;
  // sign of -c is the flipped sign; a zero factor makes the term zero anyway
  assign neg = ysel[31] ^ p_s[32] ^ q_s[32] ^ flip;

  always_comb begin
    mul_a = stqi_pkg::mag33(p_s);
    mul_b = stqi_pkg::mag33(q_s);
    unique case (phase_q)
      PH_DEN: begin
        mul_a = den_a;
        mul_b = den_b;
      end
      PH_ML: begin
        mul_a = pq_q[31:0];
        mul_b = ymag;
      end
      PH_MH: begin
        mul_a = pq_q[63:32];
        mul_b = ymag;
      end
      default: begin
        mul_a = stqi_pkg::mag33(p_s);
        mul_b = stqi_pkg::mag33(q_s);
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign r_sh = {rem_q, dq_q[NW-1]};
  assign q_bit = r_sh >= {1'b0, den_q};
  assign r_sub = r_sh - {1'b0, den_q};
  assign rnd = {rem_q, 1'b0} >= {1'b0, den_q};
  assign qext = $signed({{(AW-QW){1'b0}}, qr_q});
  assign fits = (acc_q[AW-1:31] == '0) || (acc_q[AW-1:31] == '1);

  always_comb begin
    phase_d = phase_q;
    term_d = term_q;
    cnt_d = cnt_q;
    unique case (phase_q)
      PH_IDLE: if (start_i) begin
        phase_d = PH_PQ;
        term_d = 2'd0;
      end
      PH_PQ:  phase_d = PH_DEN;
      PH_DEN: phase_d = PH_ML;
      PH_ML:  phase_d = PH_MH;
      PH_MH:  phase_d = PH_NUM;
      PH_NUM: begin
        phase_d = PH_DIV;
        cnt_d = '0;
      end
      PH_DIV: begin
        cnt_d = cnt_q + KW'(1);
        if (cnt_q == KW'(NW - 1)) phase_d = PH_RND;
      end
      PH_RND: phase_d = PH_ACC;
      PH_ACC: begin
        if (term_q == 2'd2) begin
          phase_d = PH_SAT;
        end else begin
          phase_d = PH_PQ;
          term_d = term_q + 2'd1;
        end
      end
      PH_SAT: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      term_q <= 2'd0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      term_q <= term_d;
      cnt_q <= cnt_d;
      done_q <= (phase_q == PH_SAT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      x_q <= x_i;
      x0_q <= x0_i;
      x1_q <= x1_i;
      x2_q <= x2_i;
      y0_q <= y0_i;
      y1_q <= y1_i;
      y2_q <= y2_i;
      acc_q <= '0;
    end
    if (phase_q == PH_PQ) begin
      pq_q <= mul_p;
      neg_q <= neg;
    end
    if (phase_q == PH_DEN) den_q <= mul_p;
    if (phase_q == PH_ML) lo_q <= mul_p;
    if (phase_q == PH_MH) hi_q <= mul_p;
    if (phase_q == PH_NUM) begin
      dq_q <= {32'd0, lo_q} + {hi_q, 32'd0};
      rem_q <= '0;
    end
    if (phase_q == PH_DIV) begin
      dq_q <= {dq_q[NW-2:0], q_bit};
      rem_q <= q_bit ? r_sub[63:0] : r_sh[63:0];
    end
    if (phase_q == PH_RND) qr_q <= {1'b0, dq_q} + QW'(rnd);
    if (phase_q == PH_ACC) acc_q <= neg_q ? acc_q - qext : acc_q + qext;
    if (phase_q == PH_SAT) begin
      if (fits) res_q <= acc_q[31:0];
      else res_q <= acc_q[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign done_o = done_q;
  assign result_o = res_q;

endmodule

[sv/stqi_dp.sv]
module stqi_dp #(
  parameter int unsigned DEPTH = stqi_pkg::TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          operation_i,
  input  logic [31:0]         abscissa_i,
  input  logic signed [31:0]  ordinate_i,
  input  stqi_pkg::dp_cmd_t   cmd_i,
  output stqi_pkg::dp_stat_t  stat_o,
  output logic                done_o,
  output logic signed [31:0]  value_o,
  output logic [2:0]          status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [31:0] thr_q;
  logic [1:0] op_q;
  logic [31:0] ax_q, oy_q, x_q;
  logic below_q;
  logic [AW-1:0] head_q;
  logic [CW-1:0] cnt_q, scan_q;
  logic [63:0] mem_q [DEPTH];
  logic [63:0] rd_q, w1_q, w2_q;
  logic done_q;
  logic [31:0] val_q;
  stqi_pkg::status_e st_q;

  logic [AW-1:0] head_dec, ra, wa;
  logic [CW-1:0] ridx;
  logic [31:0] rd_x, w1_x;
  logic is_append;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(idx);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign rd_x = rd_q[63:32];
  assign w1_x = w1_q[63:32];
  assign is_append = (op_q == stqi_pkg::OP_APPEND);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      stqi_pkg::RD_FIRST: ridx = '0;
      stqi_pkg::RD_LAST:  ridx = cnt_q - CW'(1);
      stqi_pkg::RD_NEXT:  ridx = scan_q + CW'(1);
      default:            ridx = '0;
    endcase
  end

  assign ra = slot_of(head_q, ridx);
  assign wa = is_append ? slot_of(head_q, cnt_q) : head_dec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[wa] <= {ax_q, oy_q};
    if (cmd_i.rd_en) rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      head_q <= '0;
      cnt_q <= '0;
      scan_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (cmd_i.wr_en) begin
        cnt_q <= cnt_q + CW'(1);
        if (!is_append) head_q <= head_dec;
      end
      if (cmd_i.scan_clr) scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + CW'(1);
      done_q <= cmd_i.res_load;
    end
  end

  logic signed [31:0] lag_res;
  logic lag_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= operation_i;
      ax_q <= abscissa_i;
      oy_q <= ordinate_i;
      x_q <= abscissa_i - thr_q;
      below_q <= abscissa_i <= thr_q;
    end
    if (cmd_i.scan_inc || cmd_i.scan_clr) begin
      w1_q <= w2_q;
      w2_q <= rd_q;
    end
    if (cmd_i.res_load) begin
      st_q <= cmd_i.res_st;
      unique case (cmd_i.res_sel)
        stqi_pkg::RES_ZERO: val_q <= '0;
        stqi_pkg::RES_RD:   val_q <= rd_q[31:0];
        stqi_pkg::RES_HIT:  val_q <= w1_q[31:0];
        stqi_pkg::RES_LAG:  val_q <= lag_res;
        default:            val_q <= '0;
      endcase
    end
  end

  stqi_lag u_lag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.lag_start),
    .x_i      (x_q),
    .x0_i     (w1_q[63:32]),
    .x1_i     (w2_q[63:32]),
    .x2_i     (rd_x),
    .y0_i     (w1_q[31:0]),
    .y1_i     (w2_q[31:0]),
    .y2_i     (rd_q[31:0]),
    .done_o   (lag_done),
    .result_o (lag_res)
  );

  always_comb begin
    stat_o.is_load = (op_q == stqi_pkg::OP_APPEND) || (op_q == stqi_pkg::OP_PREPEND);
    stat_o.is_append = is_append;
    stat_o.query_act = (op_q == stqi_pkg::OP_QUERY) && !below_q;
    stat_o.full = (cnt_q == CW'(DEPTH));
    stat_o.empty = (cnt_q == '0);
    stat_o.few = (cnt_q < CW'(3));
    stat_o.x_lt = x_q < rd_x;
    stat_o.x_eq = x_q == rd_x;
    stat_o.x_gt = x_q > rd_x;
    stat_o.ord_bad = is_append ? (ax_q <= rd_x) : (ax_q >= rd_x);
    // window is (w1, w2, rd) once three entries have come in
    stat_o.found = (x_q > w1_x) && (x_q < rd_x);
    stat_o.hit = (x_q == w1_x);
    stat_o.scan_ge2 = (scan_q >= CW'(2));
    stat_o.scan_last = (scan_q == cnt_q - CW'(1));
    stat_o.lag_done = lag_done;
  end

  assign done_o = done_q;
  assign value_o = val_q;
  assign status_o = st_q;

endmodule

[sv/stqi_ctrl.sv]
module stqi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  stqi_pkg::dp_stat_t stat_i,
  output stqi_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_LCHK   = 7'b0000100,
    S_QFIRST = 7'b0001000,
    S_QLAST  = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_LAG    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.rd_sel = stqi_pkg::RD_FIRST;
    cmd_o.res_sel = stqi_pkg::RES_ZERO;
    cmd_o.res_st = stqi_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat_i.is_load && stat_i.full) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st = stqi_pkg::ST_FULL;
        end else if (stat_i.is_load && stat_i.empty) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.res_load = 1'b1;
        end else if (stat_i.is_load) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = stat_i.is_append ? stqi_pkg::RD_LAST : stqi_pkg::RD_FIRST;
          state_d = S_LCHK;
        end else if (stat_i.query_act && stat_i.few) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st = stqi_pkg::ST_FEW;
        end else if (stat_i.query_act) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_QFIRST;
        end else begin
          cmd_o.res_load = 1'b1;
        end
      end
      S_LCHK: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.ord_bad) cmd_o.res_st = stqi_pkg::ST_ORDER;
        else cmd_o.wr_en = 1'b1;
      end
      S_QFIRST: begin
        priority if (stat_i.x_lt) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st = stqi_pkg::ST_RANGE;
        end else if (stat_i.x_eq) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel = stqi_pkg::RES_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = stqi_pkg::RD_LAST;
          state_d = S_QLAST;
        end
      end
      S_QLAST: begin
        priority if (stat_i.x_gt) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st = stqi_pkg::ST_RANGE;
        end else if (stat_i.x_eq) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel = stqi_pkg::RES_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = stqi_pkg::RD_FIRST;
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat_i.scan_ge2 && stat_i.found) begin
          cmd_o.lag_start = 1'b1;
          state_d = S_LAG;
        end else if (stat_i.scan_ge2 && stat_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel = stqi_pkg::RES_HIT;
        end else if (stat_i.scan_last) begin
          // no enclosing triple: fall back to the last three points
          cmd_o.lag_start = 1'b1;
          state_d = S_LAG;
        end else begin
          cmd_o.scan_inc = 1'b1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = stqi_pkg::RD_NEXT;
        end
      end
      S_LAG: begin
        if (stat_i.lag_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel = stqi_pkg::RES_LAG;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.res_load) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

[sim/tb_top.sv]
module tb_top;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ax;
    logic [31:0] oy;
  } table_req_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } lookup_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = stqi_pkg::OP_QUERY;
  logic [31:0]        abscissa_i = '0;
  logic signed [31:0] ordinate_i = '0;
  logic               done_o;
  logic signed [31:0] value_o;
  logic [2:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [31:0]        cfg_data_i = '0;

  sorted_table_quadratic_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .abscissa_i (abscissa_i),
    .ordinate_i (ordinate_i),
    .done_o     (done_o),
    .value_o    (value_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  table_req_t  pending_reqs[$];
  lookup_res_t expected_results[$];
  int          fail_cnt = 0;
  int          send_idle_pct = 38;
  bit          req_taken = 1'b0;

  // mirror of the block state used for prediction
  logic [31:0] tbl_x[stqi_pkg::TABLE_DEPTH];
  logic [31:0] tbl_y[stqi_pkg::TABLE_DEPTH];
  int unsigned tbl_head = 0;
  int unsigned tbl_cnt = 0;
  logic [31:0] thr_mirror = '0;

  // abscissas as the generator expects them after the queued loads
  logic [31:0] plan_xs[$];
  logic [31:0] plan_thr = '0;

  function automatic logic [31:0] pt_x(int unsigned i);
    return tbl_x[(tbl_head + i) % stqi_pkg::TABLE_DEPTH];
  endfunction

  function automatic logic [31:0] pt_y(int unsigned i);
    return tbl_y[(tbl_head + i) % stqi_pkg::TABLE_DEPTH];
  endfunction

  function automatic logic signed [129:0] lag_term(longint y, longint p, longint q,
                                                   logic [127:0] den);
    logic [127:0] num, quo, rem;
    bit neg;
    neg = (y < 0) ^ ((p < 0) ^ (q < 0));
    num = 128'(p < 0 ? -p : p) * 128'(q < 0 ? -q : q) * 128'(y < 0 ? -y : y);
    quo = num / den;
    rem = num % den;
    if (rem >= den - rem) quo = quo + 1;
    return neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  endfunction

  function automatic logic [31:0] lagrange_at(int unsigned i, longint x);
    longint x0, x1, x2, a, b, c;
    logic [127:0] d01, d12, d02;
    logic signed [129:0] acc;
    x0 = pt_x(i);
    x1 = pt_x(i + 1);
    x2 = pt_x(i + 2);
    a = x - x0;
    b = x - x1;
    c = x - x2;
    d01 = 128'(x1 - x0);
    d12 = 128'(x2 - x1);
    d02 = 128'(x2 - x0);
    acc = lag_term(longint'($signed(pt_y(i))), b, c, d01 * d02)
        + lag_term(longint'($signed(pt_y(i + 1))), a, -c, d01 * d12)
        + lag_term(longint'($signed(pt_y(i + 2))), a, b, d02 * d12);
    if (acc > 130'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -130'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  function automatic lookup_res_t table_step(table_req_t r);
    lookup_res_t res;
    logic [31:0] x;
    int unsigned i, s;
    bit hit, found;
    res.value = '0;
    res.status = stqi_pkg::ST_OK;
    if (r.op == stqi_pkg::OP_APPEND || r.op == stqi_pkg::OP_PREPEND) begin
      if (tbl_cnt >= stqi_pkg::TABLE_DEPTH) begin
        res.status = stqi_pkg::ST_FULL;
      end else if (tbl_cnt > 0 && (r.op == stqi_pkg::OP_APPEND ? r.ax <= pt_x(tbl_cnt - 1)
                                                               : r.ax >= pt_x(0))) begin
        res.status = stqi_pkg::ST_ORDER;
      end else begin
        if (r.op == stqi_pkg::OP_APPEND) begin
          s = (tbl_head + tbl_cnt) % stqi_pkg::TABLE_DEPTH;
        end else begin
          tbl_head = (tbl_head + stqi_pkg::TABLE_DEPTH - 1) % stqi_pkg::TABLE_DEPTH;
          s = tbl_head;
        end
        tbl_x[s] = r.ax;
        tbl_y[s] = r.oy;
        tbl_cnt++;
      end
    end else if (r.op == stqi_pkg::OP_QUERY && r.ax > thr_mirror) begin
      x = r.ax - thr_mirror;
      if (tbl_cnt < 3) begin
        res.status = stqi_pkg::ST_FEW;
      end else if (x < pt_x(0) || x > pt_x(tbl_cnt - 1)) begin
        res.status = stqi_pkg::ST_RANGE;
      end else if (x == pt_x(0)) begin
        res.value = pt_y(0);
      end else if (x == pt_x(tbl_cnt - 1)) begin
        res.value = pt_y(tbl_cnt - 1);
      end else begin
        hit = 0;
        found = 0;
        for (i = 0; i + 2 < tbl_cnt; i++) begin
          if (x > pt_x(i) && x < pt_x(i + 2)) begin
            found = 1;
            break;
          end
          if (x == pt_x(i)) begin
            hit = 1;
            break;
          end
        end
        if (hit) begin
          res.value = pt_y(i);
        end else begin
          if (!found) i = tbl_cnt - 3;
          res.value = lagrange_at(i, longint'(x));
        end
      end
    end
    return res;
  endfunction

  // queue a request and keep the generator's view of the table current
  function automatic void queue_req(logic [1:0] op, logic [31:0] ax, logic [31:0] oy);
    table_req_t r;
    r.op = op;
    r.ax = ax;
    r.oy = oy;
    pending_reqs.insert(pending_reqs.size(), r);
    if (plan_xs.size() < stqi_pkg::TABLE_DEPTH) begin
      if (op == stqi_pkg::OP_APPEND && (plan_xs.size() == 0 || ax > plan_xs[$]))
        plan_xs.insert(plan_xs.size(), ax);
      else if (op == stqi_pkg::OP_PREPEND && (plan_xs.size() == 0 || ax < plan_xs[0]))
        plan_xs.push_front(ax);
    end
  endfunction

  function automatic void queue_query_at(logic [31:0] x);
    logic [32:0] sum;
    sum = {1'b0, plan_thr} + {1'b0, x};
    queue_req(stqi_pkg::OP_QUERY, sum[32] ? x : sum[31:0], $urandom());
  endfunction

  function automatic logic [31:0] pick_ordinate();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_random_req();
    int unsigned p, n;
    logic [31:0] lo, hi, step;
    p = $urandom_range(0, 99);
    n = plan_xs.size();
    if (p < 35) begin
      if ($urandom_range(0, 1)) begin
        if (n > 0 && plan_xs[$] != 32'hFFFF_FFFF && $urandom_range(0, 99) < 85) begin
          step = 32'hFFFF_FFFF - plan_xs[$];
          if (step > 32'h0400_0000) step = 32'h0400_0000;
          queue_req(stqi_pkg::OP_APPEND, plan_xs[$] + $urandom_range(1, step),
                    pick_ordinate());
        end else begin
          queue_req(stqi_pkg::OP_APPEND, $urandom(), pick_ordinate());
        end
      end else begin
        if (n > 0 && plan_xs[0] != 0 && $urandom_range(0, 99) < 85) begin
          step = plan_xs[0];
          if (step > 32'h0400_0000) step = 32'h0400_0000;
          queue_req(stqi_pkg::OP_PREPEND, plan_xs[0] - $urandom_range(1, step),
                    pick_ordinate());
        end else begin
          queue_req(stqi_pkg::OP_PREPEND, $urandom(), pick_ordinate());
        end
      end
    end else if (p < 42 || n == 0) begin
      queue_req(stqi_pkg::OP_QUERY, $urandom(), $urandom());
    end else if (p < 52) begin
      queue_query_at(plan_xs[$urandom_range(0, n - 1)]);
    end else if (p < 55) begin
      queue_req(stqi_pkg::OP_QUERY, $urandom_range(0, plan_thr), $urandom());
    end else if (p < 57) begin
      queue_req(stqi_pkg::OP_NONE, $urandom(), $urandom());
    end else begin
      lo = plan_xs[0];
      hi = plan_xs[$];
      queue_query_at($urandom_range(lo, hi));
    end
  endfunction

  always @(negedge clk_i) begin
    table_req_t r;
    if (rst_ni && (!start || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        start <= 1'b1;
        operation_i <= r.op;
        abscissa_i <= r.ax;
        ordinate_i <= r.oy;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_res_t want;
    table_req_t r;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: value %h status %0d",
                 value_o, status_o);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %h actual %h", want.value, value_o);
            fail_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status_o);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        r.op = operation_i;
        r.ax = abscissa_i;
        r.oy = ordinate_i;
        expected_results.insert(expected_results.size(), table_step(r));
      end
      if (cfg_valid_i && cfg_ready_o) thr_mirror = cfg_data_i;
      req_taken = start && !busy;
    end
  end

  task automatic write_threshold(logic [31:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    plan_thr = v;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !start && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] thr_set[4];
    int          idle_set[4];
    int          cnt_set[4];
    thr_set = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
    idle_set = '{38, 81, 0, 38};
    cnt_set = '{200, 90, 150, 90};
    thr_set[2] = $urandom_range(1, 32'h3FFF_FFFF);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty table, ordering errors, end points, interpolation, extremes
    send_idle_pct = idle_set[0];
    write_threshold(32'h0);
    queue_req(stqi_pkg::OP_QUERY, 32'h8000_0000, '0);
    queue_req(stqi_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(stqi_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(stqi_pkg::OP_APPEND, 32'h8000_0000, 32'h1);
    queue_req(stqi_pkg::OP_PREPEND, 32'h8000_0000, 32'h1);
    queue_req(stqi_pkg::OP_QUERY, 32'h8000_0000, '0);
    queue_req(stqi_pkg::OP_PREPEND, 32'h7000_0000, 32'h8000_0000);
    queue_req(stqi_pkg::OP_APPEND, 32'h9000_0000, 32'h0001_0000);
    queue_req(stqi_pkg::OP_QUERY, 32'h0, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h6000_0000, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'hFFFF_FFFF, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h7000_0000, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h9000_0000, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h8000_0000, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h7800_0000, '0);
    queue_req(stqi_pkg::OP_QUERY, 32'h8800_0001, '0);
    queue_req(stqi_pkg::OP_APPEND, 32'h9000_0002, 32'h7FFF_FFFF);
    queue_req(stqi_pkg::OP_QUERY, 32'h9000_0001, '0);
    queue_req(stqi_pkg::OP_PREPEND, 32'h6FFF_FFFF, 32'h8000_0000);
    queue_req(stqi_pkg::OP_QUERY, 32'h7000_0000, '0);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        send_idle_pct = idle_set[ph];
        write_threshold(thr_set[ph]);
      end
      for (int k = 0; k < cnt_set[ph]; k++) queue_random_req();
    end
    // push the low end to zero and the high end to the top if room allows
    queue_req(stqi_pkg::OP_PREPEND, 32'h0, 32'h8000_0000);
    queue_req(stqi_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_req(stqi_pkg::OP_QUERY, 32'hFFFF_FFFF, '0);
    drain();
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
sv/stqi_pkg.sv
sv/stqi_lag.sv
sv/stqi_dp.sv
sv/stqi_ctrl.sv
sv/sorted_table_quadratic_interpolator.sv
sim/tb_top.sv
